### rtl/tkhb_pkg.sv
`default_nettype none

package tkhb_pkg;

   localparam int unsigned KindWidth     = 3;
   localparam int unsigned KeyWidth      = 64;
   localparam int unsigned BucketWidth   = 32;
   localparam int unsigned CountWidth    = 31;
   localparam int unsigned HashWidth     = 32;
   localparam int unsigned DivStepWidth  = 6;

   localparam logic [KindWidth-1:0] KIND_INT32  = 3'd0;
   localparam logic [KindWidth-1:0] KIND_INT16  = 3'd1;
   localparam logic [KindWidth-1:0] KIND_INT8   = 3'd2;
   localparam logic [KindWidth-1:0] KIND_INT64  = 3'd3;
   localparam logic [KindWidth-1:0] KIND_UINT64 = 3'd4;
   localparam logic [KindWidth-1:0] KIND_BYTES  = 3'd5;

   localparam logic [CountWidth-1:0] BUCKET_COUNT_RESET = 31'd1024;

   localparam logic [HashWidth-1:0] PJW_TOP_MASK   = 32'hf << (HashWidth - 4);
   localparam int unsigned          PJW_FOLD_SHIFT = HashWidth - 8;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_DELIVER
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [KeyWidth-1:0]   dividend;
      logic [CountWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [CountWidth-1:0] remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

### rtl/tkhb_req_if.sv
`default_nettype none

interface tkhb_req_if import tkhb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] key_kind;
   logic [KeyWidth-1:0]  key_value;
   logic                 has_byte;
   logic                 last_item;

   modport source (output valid, key_kind, key_value, has_byte, last_item, input ready);
   modport sink   (input valid, key_kind, key_value, has_byte, last_item, output ready);
endinterface

`default_nettype wire

### rtl/tkhb_rsp_if.sv
`default_nettype none

interface tkhb_rsp_if import tkhb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [BucketWidth-1:0] bucket_index;
   logic                   kind_error;

   modport source (output valid, bucket_index, kind_error, input ready);
   modport sink   (input valid, bucket_index, kind_error, output ready);
endinterface

`default_nettype wire

### rtl/tkhb_csr_if.sv
`default_nettype none

interface tkhb_csr_if import tkhb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CountWidth-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/typed_key_hash_bucket_core.sv
// Typed key hash bucket core.
// The req channel carries one word per integer key, or one word per byte of a
// byte-string key. The rsp channel returns one word per integer key, per
// invalid kind and per finished string; mid-string bytes return nothing.
// The csr channel writes bucket_count and is always ready; write it only
// while no key is in flight.
// An integer key or a finished string launches the remainder unit at the accept
// edge; the unit takes one dividend bit per cycle, then the sign is applied as
// the remainder is loaded into the result register, and from there the result
// moves to the output register once that is free. An invalid kind or a zero
// bucket count skips the remainder unit and goes straight to the result register
// and then the output register. A mid-string byte is absorbed in its accept cycle
// and the next byte may follow at once. Req takes no new key until the previous
// result has moved to the output register; bytes go one per cycle while no key is in flight.
// The response sits in an output register; req is ready again as soon as a
// result has moved there, so a stalled receiver blocks only the next result.
// Reset sets bucket_count to 1024, clears the hash and drops rsp valid.
`default_nettype none

module typed_key_hash_bucket_core import tkhb_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   tkhb_req_if.sink   req_chan,
   tkhb_rsp_if.source rsp_chan,
   tkhb_csr_if.sink   csr_wr
);

   state_type              state_ff, state_in;
   logic [CountWidth-1:0]  bucket_count_ff, bucket_count_in;
   logic [HashWidth-1:0]   hash_ff, hash_in;
   logic                   neg_ff, neg_in;
   logic [BucketWidth-1:0] result_ff, result_in;
   logic                   result_err_ff, result_err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BucketWidth-1:0] rsp_bucket_ff, rsp_bucket_in;
   logic                   rsp_err_ff, rsp_err_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [KeyWidth-1:0]  key_sext;
   logic [KeyWidth-1:0]  op_dividend;
   logic                 op_neg;
   logic                 op_valid_kind;
   logic                 op_result;
   logic [HashWidth-1:0] hash_next;
   logic                 zero_div;
   logic                 out_free;

   function automatic logic [HashWidth-1:0] pjw_absorb(
      input logic [HashWidth-1:0] h_old,
      input logic [7:0]           b
   );
      logic [HashWidth-1:0] h;
      logic [HashWidth-1:0] g;
      h = (h_old << 4) + {{(HashWidth-8){b[7]}}, b};
      g = h & PJW_TOP_MASK;
      // The fold is a no-op when the top nibble is clear.
      h = h ^ (g >> PJW_FOLD_SHIFT) ^ g;
      return h;
   endfunction

   assign zero_div = (bucket_count_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Operand selection for the accepted word.
   always_comb begin
      hash_next     = pjw_absorb(hash_ff, req_chan.key_value[7:0]);
      key_sext      = req_chan.key_value;
      op_valid_kind = 1'b1;
      op_result     = 1'b1;
      op_neg        = 1'b0;
      unique case (req_chan.key_kind)
         KIND_INT32: key_sext = {{32{req_chan.key_value[31]}}, req_chan.key_value[31:0]};
         KIND_INT16: key_sext = {{48{req_chan.key_value[15]}}, req_chan.key_value[15:0]};
         KIND_INT8:  key_sext = {{56{req_chan.key_value[7]}}, req_chan.key_value[7:0]};
         KIND_INT64: key_sext = req_chan.key_value;
         KIND_UINT64: key_sext = req_chan.key_value;
         KIND_BYTES: begin
            key_sext = {{(KeyWidth-HashWidth){1'b0}},
                        req_chan.has_byte ? hash_next : hash_ff};
            op_result = !req_chan.has_byte || req_chan.last_item;
         end
         default: op_valid_kind = 1'b0;
      endcase
      case (req_chan.key_kind) inside
         KIND_INT32, KIND_INT16, KIND_INT8, KIND_INT64: op_neg = key_sext[KeyWidth-1];
         default: op_neg = 1'b0;
      endcase
      op_dividend = op_neg ? (KeyWidth'(0) - key_sext) : key_sext;
   end

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      bucket_count_in = bucket_count_ff;
      hash_in         = hash_ff;
      neg_in          = neg_ff;
      result_in       = result_ff;
      result_err_in   = result_err_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_bucket_in   = rsp_bucket_ff;
      rsp_err_in      = rsp_err_ff;
      div_req.start    = 1'b0;
      div_req.dividend = op_dividend;
      div_req.divisor  = bucket_count_ff;
      req_chan.ready   = (state_ff == S_IDLE);

      if (csr_wr.valid) begin
         bucket_count_in = csr_wr.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               if (!op_valid_kind) begin
                  result_in     = '1;
                  result_err_in = 1'b1;
                  state_in      = S_DELIVER;
               end else if (!op_result) begin
                  hash_in = hash_next;
               end else begin
                  if (req_chan.key_kind == KIND_BYTES) begin
                     hash_in = '0;
                  end
                  neg_in        = op_neg;
                  result_err_in = 1'b0;
                  if (zero_div) begin
                     result_in = key_sext[BucketWidth-1:0];
                     state_in  = S_DELIVER;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = S_DIVIDE;
                  end
               end
            end
         end
         S_DIVIDE: begin
            if (div_rsp.done) begin
               result_in = neg_ff ? (BucketWidth'(0) - {1'b0, div_rsp.remainder})
                                  : {1'b0, div_rsp.remainder};
               state_in  = S_DELIVER;
            end
         end
         S_DELIVER: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = result_ff;
               rsp_err_in    = result_err_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         bucket_count_ff <= BUCKET_COUNT_RESET;
         hash_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         bucket_count_ff <= bucket_count_in;
         hash_ff         <= hash_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      neg_ff        <= neg_in;
      result_ff     <= result_in;
      result_err_ff <= result_err_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_err_ff    <= rsp_err_in;
   end

   tkhb_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign csr_wr.ready          = 1'b1;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.bucket_index = rsp_bucket_ff;
   assign rsp_chan.kind_error   = rsp_err_ff;

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIVIDE)
      else $error("remainder finished outside the divide state");

   a_err_all_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_bucket_ff == '1)
      else $error("kind error word without all-ones bucket");

   a_deliver_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DELIVER && out_free |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("pending result not moved to the output register");

   a_bad_kind_hash: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && !op_valid_kind |=> hash_ff == $past(hash_ff))
      else $error("invalid kind changed the hash");

endmodule

`default_nettype wire

### rtl/tkhb_divider.sv
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle, quotient discarded.
module tkhb_divider import tkhb_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DivStepWidth-1:0] step_ff, step_in;
   logic [KeyWidth-1:0]     num_ff, num_in;
   logic [CountWidth-1:0]   rem_ff, rem_in;
   logic [CountWidth-1:0]   den_ff, den_in;

   logic [CountWidth:0]     shifted;
   logic [CountWidth+1:0]   diff;

   always_comb begin
      shifted = {rem_ff, num_ff[KeyWidth-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         num_in  = {num_ff[KeyWidth-2:0], 1'b0};
         // The difference is non-negative exactly when the divisor fits.
         rem_in  = diff[CountWidth+1] ? shifted[CountWidth-1:0] : diff[CountWidth-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == DivStepWidth'(KeyWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && step_ff == '0)
      else $error("divider done while still stepping");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff && den_ff != '0 |-> rem_ff < den_ff)
      else $error("remainder not below divisor");

endmodule

`default_nettype wire
